// ----- sv/kcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants of the k-means color clustering block.
// ---------------------------------------------------------------------------
package kcc_pkg;

  localparam int MaxPixels   = 4096;
  localparam int MaxClusters = 8;
  localparam int PixAw       = $clog2(MaxPixels);
  localparam int CntW        = PixAw + 1;
  localparam int ClAw        = $clog2(MaxClusters);
  localparam int SumW        = CntW + 8;

  // input actions
  typedef enum logic [2:0] {
    ActClear  = 3'd0,
    ActAppend = 3'd1,
    ActLoad   = 3'd2,
    ActRun    = 3'd3,
    ActQuery  = 3'd4
  } action_e;

  // result kinds
  typedef enum logic [1:0] {
    KindAck      = 2'd0,
    KindCentroid = 2'd1,
    KindQuery    = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic [1:0] CfgClusterCount   = 2'd0;
  localparam logic [1:0] CfgIterationLimit = 2'd1;
  localparam logic [1:0] CfgTolerance      = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] item_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] cluster;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] passes_done;
    logic       last_result;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    action_e     action;
    logic [23:0] rgb;
    logic [11:0] item_index;
  } req_t;

endpackage
`default_nettype wire

// ----- sv/kcc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kcc_front
// Accepts input requests, drops unknown actions, queues the rest.
// ---------------------------------------------------------------------------
module kcc_front import kcc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          req_valid_o,
  input  wire logic     req_ready_i,
  output req_t          req_o
);

  localparam int Depth = 4;

  req_t       fifo_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       push, pop, known;

  // classify: actions above query carry no work
  assign known    = (in_data.action <= ActQuery);
  assign in_ready = (cnt_q != 3'(Depth));
  assign push     = in_valid && in_ready && known;
  assign pop      = req_valid_o && req_ready_i;
  assign req_valid_o = (cnt_q != 3'd0);
  assign req_o       = fifo_q[rd_q];

  // request queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{action: action_e'(in_data.action),
                        rgb: {in_data.red, in_data.green, in_data.blue},
                        item_index: in_data.item_index};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (pop)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/kcc_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kcc_divider
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ---------------------------------------------------------------------------
module kcc_divider import kcc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] dividend_i,
  input  wire logic [CntW-1:0] divisor_i,
  output logic                 done_o,
  output logic [7:0]           quot_o
);

  logic [SumW-1:0] rem_q;
  logic [CntW-1:0] div_q;
  logic [3:0]      step_q;
  logic            busy_q;
  logic [SumW:0]   trial;
  logic [SumW:0]   shifted;

  // mean fits in 8 bits, so only the low 8 quotient bits are ever set
  assign shifted = {1'b0, rem_q};
  assign trial   = {1'b0, div_q, 8'd0} >> (4'd1 + step_q);
  assign done_o  = busy_q && (step_q == 4'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quot_o <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      rem_q  <= dividend_i;
      div_q  <= divisor_i;
      quot_o <= '0;
    end else if (busy_q) begin
      if (step_q == 4'd8) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
        if (shifted >= trial) begin
          rem_q  <= SumW'(shifted - trial);
          quot_o <= {quot_o[6:0], 1'b1};
        end else begin
          quot_o <= {quot_o[6:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/kcc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kcc_back
// Executes queued requests: pixel store, centroid loads, Lloyd passes,
// queries, and result output register.
// ---------------------------------------------------------------------------
module kcc_back import kcc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire req_t      req_i,
  input  wire logic [3:0] cluster_count_i,
  input  wire logic [9:0] iteration_limit_i,
  input  wire logic [7:0] tolerance_i,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [3:0] {
    StIdle, StPassInit, StRead, StAssign, StAccum, StDivStart, StDivWait,
    StMove, StPassEnd, StEmit, StQuery
  } state_e;

  state_e state_q;

  // memories
  logic [23:0]     pix_mem [MaxPixels];
  logic [ClAw-1:0] asg_mem [MaxPixels];
  logic [23:0]     pix_rd_q;
  logic [ClAw-1:0] asg_rd_q;

  logic [CntW-1:0] total_q;
  logic [23:0]     cent_q  [MaxClusters];
  logic [SumW-1:0] sum_q   [MaxClusters][3];
  logic [CntW-1:0] cnt_q   [MaxClusters];
  logic [9:0]      passes_q;
  logic [3:0]      k_q;
  logic [PixAw:0]  pi_q;
  logic [ClAw:0]   ci_q;
  logic [1:0]      ch_q;
  logic [7:0]      new_q [3];
  logic [20:0]     moved_q;
  logic [ClAw-1:0] best_q;
  logic [17:0]     bestd_q;
  // assignments below this index have been written since reset
  logic [CntW-1:0] asg_fill_q;
  logic            qvalid_q;

  // divider
  logic            div_start, div_done;
  logic [7:0]      div_quot;
  logic [SumW-1:0] div_num;

  assign req_ready_o = (state_q == StIdle) && !out_valid;

  // distance of fetched pixel to centroid ci_q
  logic [ClAw-1:0] ci_idx;
  logic [8:0]      dr, dg, db;
  logic [17:0]     pix_dist;
  logic [23:0]     cc;
  assign ci_idx = ci_q[ClAw-1:0];
  assign cc     = cent_q[ci_idx];
  assign dr   = {1'b0, pix_rd_q[23:16]} - {1'b0, cc[23:16]};
  assign dg   = {1'b0, pix_rd_q[15:8]}  - {1'b0, cc[15:8]};
  assign db   = {1'b0, pix_rd_q[7:0]}   - {1'b0, cc[7:0]};
  function automatic logic [15:0] sq9(input logic [8:0] d);
    logic [7:0] a;
    a = d[8] ? 8'(-d) : d[7:0];
    return 16'(a) * 16'(a);
  endfunction
  assign pix_dist = 18'(sq9(dr)) + 18'(sq9(dg)) + 18'(sq9(db));

  // movement of new centroid
  logic [8:0]  mr, mg, mb;
  logic [17:0] mdist;
  assign mr    = {1'b0, new_q[0]} - {1'b0, cc[23:16]};
  assign mg    = {1'b0, new_q[1]} - {1'b0, cc[15:8]};
  assign mb    = {1'b0, new_q[2]} - {1'b0, cc[7:0]};
  assign mdist = 18'(sq9(mr)) + 18'(sq9(mg)) + 18'(sq9(mb));

  assign div_num   = sum_q[ci_idx][ch_q];
  assign div_start = (state_q == StDivStart);

  kcc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (cnt_q[ci_idx]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic [PixAw-1:0] pa;
  assign pa = pi_q[PixAw-1:0];

  // pixel and assignment memories
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i && !out_valid && req_i.action == ActAppend
        && total_q < CntW'(MaxPixels)) begin
      pix_mem[total_q[PixAw-1:0]] <= req_i.rgb;
    end
    if (state_q == StAccum) asg_mem[pa] <= best_q;
    pix_rd_q <= pix_mem[pa];
    asg_rd_q <= asg_mem[req_i.item_index[PixAw-1:0]];
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      out_valid  <= 1'b0;
      out_data   <= '0;
      total_q    <= '0;
      passes_q   <= '0;
      k_q        <= '0;
      pi_q       <= '0;
      ci_q       <= '0;
      ch_q       <= '0;
      moved_q    <= '0;
      best_q     <= '0;
      bestd_q    <= '0;
      asg_fill_q <= '0;
      qvalid_q   <= 1'b0;
      for (int c = 0; c < MaxClusters; c++) begin
        cent_q[c] <= '0;
        cnt_q[c]  <= '0;
        for (int j = 0; j < 3; j++) sum_q[c][j] <= '0;
      end
      for (int j = 0; j < 3; j++) new_q[j] <= '0;
    end else begin
      // the emit state drives out_valid itself
      if (out_valid && out_ready && state_q != StEmit) out_valid <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req_valid_i && !out_valid) begin
            out_data <= '{kind: KindAck, cluster: 3'd0, out_red: 8'd0,
                          out_green: 8'd0, out_blue: 8'd0,
                          passes_done: passes_q, last_result: 1'b1};
            case (req_i.action)
              ActClear: begin
                total_q   <= '0;
                out_valid <= 1'b1;
              end
              ActAppend: begin
                if (total_q < CntW'(MaxPixels)) total_q <= total_q + 1'b1;
                out_valid <= 1'b1;
              end
              ActLoad: begin
                if (req_i.item_index < 12'(MaxClusters))
                  cent_q[req_i.item_index[ClAw-1:0]] <= req_i.rgb;
                out_valid <= 1'b1;
              end
              ActRun: begin
                if (cluster_count_i == 4'd0) k_q <= 4'd1;
                else if (cluster_count_i > 4'(MaxClusters)) k_q <= 4'(MaxClusters);
                else k_q <= cluster_count_i;
                passes_q <= '0;
                ci_q     <= '0;
                state_q  <= (iteration_limit_i == 10'd0) ? StEmit : StPassInit;
              end
              ActQuery: begin
                qvalid_q <= ({1'b0, req_i.item_index} < total_q) &&
                            ({1'b0, req_i.item_index} < asg_fill_q);
                state_q  <= StQuery;
              end
              default: ;
            endcase
          end
        end
        StQuery: begin
          out_data.kind    <= KindQuery;
          out_data.cluster <= qvalid_q ? 3'(asg_rd_q) : 3'd0;
          out_valid        <= 1'b1;
          state_q          <= StIdle;
        end
        StPassInit: begin
          for (int c = 0; c < MaxClusters; c++) begin
            cnt_q[c] <= '0;
            for (int j = 0; j < 3; j++) sum_q[c][j] <= '0;
          end
          pi_q    <= '0;
          moved_q <= '0;
          state_q <= (total_q == '0) ? StPassEnd : StRead;
        end
        StRead: begin
          ci_q    <= '0;
          state_q <= StAssign;
        end
        StAssign: begin
          // one centroid compared per cycle, strict less keeps lower index
          if (ci_q == '0 || pix_dist < bestd_q) begin
            bestd_q <= pix_dist;
            best_q  <= ci_idx;
          end
          if (ci_q + 1'b1 >= (ClAw+1)'(k_q)) state_q <= StAccum;
          else ci_q <= ci_q + 1'b1;
        end
        StAccum: begin
          cnt_q[best_q]    <= cnt_q[best_q] + 1'b1;
          sum_q[best_q][0] <= sum_q[best_q][0] + SumW'(pix_rd_q[23:16]);
          sum_q[best_q][1] <= sum_q[best_q][1] + SumW'(pix_rd_q[15:8]);
          sum_q[best_q][2] <= sum_q[best_q][2] + SumW'(pix_rd_q[7:0]);
          if (pi_q + 1'b1 > asg_fill_q) asg_fill_q <= pi_q + 1'b1;
          if (pi_q + 1'b1 >= (PixAw+1)'(total_q)) begin
            ci_q    <= '0;
            ch_q    <= '0;
            state_q <= StDivStart;
          end else begin
            pi_q    <= pi_q + 1'b1;
            state_q <= StRead;
          end
        end
        StDivStart: begin
          if (cnt_q[ci_idx] == '0) begin
            // empty cluster keeps its color
            if (ci_q + 1'b1 >= (ClAw+1)'(k_q)) state_q <= StPassEnd;
            else ci_q <= ci_q + 1'b1;
          end else begin
            state_q <= StDivWait;
          end
        end
        StDivWait: begin
          if (div_done) begin
            new_q[ch_q] <= div_quot;
            if (ch_q == 2'd2) state_q <= StMove;
            else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= StDivStart;
            end
          end
        end
        StMove: begin
          moved_q        <= moved_q + 21'(mdist);
          cent_q[ci_idx] <= {new_q[0], new_q[1], new_q[2]};
          ch_q           <= '0;
          if (ci_q + 1'b1 >= (ClAw+1)'(k_q)) state_q <= StPassEnd;
          else begin
            ci_q    <= ci_q + 1'b1;
            state_q <= StDivStart;
          end
        end
        StPassEnd: begin
          passes_q <= passes_q + 10'd1;
          ci_q     <= '0;
          if (moved_q <= 21'(tolerance_i) || passes_q + 10'd1 >= iteration_limit_i)
            state_q <= StEmit;
          else
            state_q <= StPassInit;
        end
        StEmit: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.kind         <= KindCentroid;
            out_data.cluster      <= 3'(ci_q);
            out_data.out_red      <= cc[23:16];
            out_data.out_green    <= cc[15:8];
            out_data.out_blue     <= cc[7:0];
            out_data.passes_done  <= passes_q;
            out_data.last_result  <= (ci_q + 1'b1 >= (ClAw+1)'(k_q));
            if (ci_q + 1'b1 >= (ClAw+1)'(k_q)) state_q <= StIdle;
            else ci_q <= ci_q + 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/kmeans_color_clustering.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmeans_color_clustering
// Lloyd k-means color quantization over up to 4096 RGB pixels.
// ---------------------------------------------------------------------------
// Clear, append, load and query requests are handled one at a time in the
// back end; the front queue holds four requests. Each pass of a run assigns
// every pixel with the single distance unit stepping one centroid a cycle,
// then runs the bit-serial mean divider for each non-empty cluster; after the
// last pass the k centroids are emitted.
module kmeans_color_clustering import kcc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  logic [3:0] cluster_count_q;
  logic [9:0] iteration_limit_q;
  logic [7:0] tolerance_q;
  logic       req_valid, req_ready;
  req_t       req;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q   <= 4'd8;
      iteration_limit_q <= 10'd16;
      tolerance_q       <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgClusterCount:   cluster_count_q   <= cfg_data[3:0];
        CfgIterationLimit: iteration_limit_q <= cfg_data;
        CfgTolerance:      tolerance_q       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  kcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  kcc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_valid),
    .req_ready_o       (req_ready),
    .req_i             (req),
    .cluster_count_i   (cluster_count_q),
    .iteration_limit_i (iteration_limit_q),
    .tolerance_i       (tolerance_q),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule
`default_nettype wire
